[rtl/sdx_pkg.sv]
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared types, character constants and helpers for the soundex word encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

    localparam int CODE_W  = 39;
    localparam int DIGIT_W = 3;

    localparam logic [CODE_W-1:0] CODES_A_M_RESET = 39'd380373599880;
    localparam logic [CODE_W-1:0] CODES_N_Z_RESET = 39'd139604091973;

    localparam logic REG_CODES_A_M = 1'b0;
    localparam logic REG_CODES_N_Z = 1'b1;

    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_F     = 8'h46;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] ASCII_TOP  = 8'd127;

    localparam logic [DIGIT_W-1:0] NONE_DIGIT = 3'd7;
    localparam logic [DIGIT_W-1:0] ZERO_DIGIT = 3'd0;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_AFTER_P = 2'd1,
        PH_BODY    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CODE_W-1:0] codes_n_z;
        logic [CODE_W-1:0] codes_a_m;
    } t_code_table;

    typedef struct packed {
        logic               bad_word;
        logic [DIGIT_W-1:0] digit_three;
        logic [DIGIT_W-1:0] digit_two;
        logic [DIGIT_W-1:0] digit_one;
        logic [7:0]         lead_letter;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return (c <= ASCII_TOP) &&
               (((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
                ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) ? c - CASE_GAP : c;
    endfunction

endpackage

[rtl/sdx_cfg.sv]
// ----------------------------------------------------------------------------
// sdx_cfg
// APB register file holding the two letter-to-digit code tables.
// ----------------------------------------------------------------------------
module sdx_cfg
    import sdx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_code_table o_codes
);

    logic [CODE_W-1:0] r_codes_a_m;
    logic [CODE_W-1:0] r_codes_n_z;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes_a_m <= CODES_A_M_RESET;
            r_codes_n_z <= CODES_N_Z_RESET;
        end else if (w_wr) begin
            if (paddr[3] == REG_CODES_A_M) begin
                r_codes_a_m <= pwdata[CODE_W-1:0];
            end else begin
                r_codes_n_z <= pwdata[CODE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == REG_CODES_N_Z) begin
            prdata = {{(64-CODE_W){1'b0}}, r_codes_n_z};
        end else begin
            prdata = {{(64-CODE_W){1'b0}}, r_codes_a_m};
        end
    end

    assign o_codes.codes_a_m = r_codes_a_m;
    assign o_codes.codes_n_z = r_codes_n_z;

endmodule

[rtl/sdx_word.sv]
// ----------------------------------------------------------------------------
// sdx_word
// Per-word state: lead letter, digit dedup and packing, error tracking.
// ----------------------------------------------------------------------------
module sdx_word
    import sdx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    input  t_code_table i_codes,
    output t_result     o_result
);

    t_phase               r_phase,      n_phase;
    logic [7:0]           r_first,      n_first;
    logic [DIGIT_W-1:0]   r_last_digit, n_last_digit;
    logic [3*DIGIT_W-1:0] r_kept,       n_kept;
    logic [1:0]           r_count,      n_count;
    logic                 r_err,        n_err;

    logic [7:0]           w_upper;
    logic                 w_letter;
    logic [4:0]           w_idx;
    logic [6:0]           w_bit;
    logic [2*CODE_W-1:0]  w_table;
    logic [DIGIT_W-1:0]   w_raw;
    logic [DIGIT_W-1:0]   w_digit;
    logic                 w_body;

    assign w_upper  = to_upper(i_char);
    assign w_letter = is_letter(i_char);
    assign w_idx    = w_upper[4:0] - CHAR_UP_A[4:0];
    assign w_bit    = {2'b00, w_idx} * 7'd3;
    assign w_table  = {i_codes.codes_n_z, i_codes.codes_a_m};
    assign w_raw    = w_table[w_bit +: DIGIT_W];
    assign w_digit  = (w_raw == NONE_DIGIT) ? ZERO_DIGIT : w_raw;

    always_comb begin
        n_phase      = r_phase;
        n_first      = r_first;
        n_last_digit = r_last_digit;
        n_kept       = r_kept;
        n_count      = r_count;
        n_err        = r_err | (i_char == CHAR_SPACE);
        w_body       = 1'b0;

        unique case (r_phase)
            PH_FIRST: begin
                if (!w_letter) begin
                    n_err = 1'b1;
                end
                n_first = w_upper;
                n_phase = (w_upper == CHAR_P) ? PH_AFTER_P : PH_BODY;
            end
            PH_AFTER_P: begin
                n_phase = PH_BODY;
                if (w_upper == CHAR_H) begin
                    n_first = CHAR_F;
                end else begin
                    w_body = 1'b1;
                end
            end
            default: begin
                w_body = 1'b1;
            end
        endcase

        if (w_body && w_letter && (w_digit != r_last_digit)) begin
            n_last_digit = w_digit;
            if ((w_digit != ZERO_DIGIT) && (r_count != 2'd3)) begin
                n_count = r_count + 2'd1;
                unique case (r_count)
                    2'd0:    n_kept[2:0] = w_digit;
                    2'd1:    n_kept[5:3] = w_digit;
                    default: n_kept[8:6] = w_digit;
                endcase
            end
        end

        if (n_err) begin
            o_result = '0;
            o_result.bad_word = 1'b1;
        end else begin
            o_result.lead_letter = n_first;
            o_result.digit_one   = n_kept[2:0];
            o_result.digit_two   = n_kept[5:3];
            o_result.digit_three = n_kept[8:6];
            o_result.bad_word    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase      <= PH_FIRST;
            r_first      <= '0;
            r_last_digit <= NONE_DIGIT;
            r_kept       <= '0;
            r_count      <= '0;
            r_err        <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_first      <= n_first;
            r_last_digit <= n_last_digit;
            r_kept       <= n_kept;
            r_count      <= n_count;
            r_err        <= n_err;
        end
    end

endmodule

[rtl/soundex_word_encoder.sv]
// ----------------------------------------------------------------------------
// soundex_word_encoder
// Streams a word one byte per transaction and emits its soundex code.
//
//   channel  | direction | carries
//   s_axis   | in        | one byte of the word, tlast on the final byte
//   m_axis   | out       | lead letter and three digits, tuser = bad word
//   apb      | in/out    | letter code tables at 0x0 (a-m) and 0x8 (n-z)
//
// One byte is taken per cycle while s_axis_tready is high; the code appears in the cycle after the last byte.
// The lookup and dedup sit between the word state and the result register.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
// Reset clears the word state and loads the default code tables.
// ----------------------------------------------------------------------------
module soundex_word_encoder
    import sdx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] lead_letter, [10:8] digit_one,
                                        // [13:11] digit_two, [16:14] digit_three
    output logic        m_axis_tuser,   // [0] bad_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_code_table w_codes;
    t_result     w_result;
    t_result     r_out;
    logic        r_out_valid;
    logic        w_accept;

    sdx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_codes (w_codes)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    sdx_word u_word (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_codes  (w_codes),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tlast) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.digit_three, r_out.digit_two,
                            r_out.digit_one, r_out.lead_letter};
    assign m_axis_tuser  = r_out.bad_word;

endmodule

[rtl/sdx_checker.sv]
// ----------------------------------------------------------------------------
// sdx_checker
// Port-level checks on the soundex word encoder, bound to the top level.
// ----------------------------------------------------------------------------
module sdx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(m_axis_tvalid && !m_axis_tready) |-> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("bad word carries nonzero code");

    a_digits_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[10:8] == 3'd0)
        |-> (m_axis_tdata[13:11] == 3'd0) && (m_axis_tdata[16:14] == 3'd0))
        else $error("digits not packed from the first slot");

endmodule

bind soundex_word_encoder sdx_checker u_sdx_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the soundex word encoder. Words go in as byte transactions
// on the slave stream; every code that comes out of the master stream is
// checked field by field against an in-bench predictor of the encoder.
// The letter code tables are rewritten between phases, extremes included,
// and both stream sides idle at random in all but one phase.
// ----------------------------------------------------------------------------
module tb;
    import sdx_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 200;
    localparam logic [CODE_W-1:0] CODES_ALL_ONES = {CODE_W{1'b1}};
    localparam logic [CODE_W-1:0] CODES_ALL_ZERO = '0;

    class soundex_scoreboard;
        logic [CODE_W-1:0] codes_am;
        logic [CODE_W-1:0] codes_nz;
        t_phase            phase;
        logic [7:0]        lead;
        logic [2:0]        prev_digit;
        logic [2:0]        kept [3];
        int                n_kept;
        bit                bad;
        t_result           pending_codes [$];
        int                errors;

        function new();
            codes_am = CODES_A_M_RESET;
            codes_nz = CODES_N_Z_RESET;
            errors   = 0;
            clear_word();
        endfunction

        function void clear_word();
            phase      = PH_FIRST;
            lead       = '0;
            prev_digit = NONE_DIGIT;
            kept       = '{default: ZERO_DIGIT};
            n_kept     = 0;
            bad        = 1'b0;
        endfunction

        function void set_codes(logic idx, logic [CODE_W-1:0] val);
            if (idx == REG_CODES_A_M) begin
                codes_am = val;
            end else begin
                codes_nz = val;
            end
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z);
        endfunction

        function logic [7:0] upcase(logic [7:0] c);
            return (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? c - CASE_GAP : c;
        endfunction

        function logic [2:0] digit_of(logic [7:0] c);
            int         pos;
            logic [2:0] d;
            pos = upcase(c) - CHAR_UP_A;
            d = (pos < 13) ? codes_am[3*pos +: 3] : codes_nz[3*(pos-13) +: 3];
            return (d == NONE_DIGIT) ? ZERO_DIGIT : d;
        endfunction

        // Skip non-letters; keep a digit only when it changes, drop zeros.
        function void add_body(logic [7:0] c);
            logic [2:0] d;
            if (!alpha(c)) return;
            d = digit_of(c);
            if (d != prev_digit) begin
                if (d != ZERO_DIGIT && n_kept < 3) begin
                    kept[n_kept] = d;
                    n_kept++;
                end
                prev_digit = d;
            end
        endfunction

        function void take_byte(logic [7:0] c, bit last);
            t_result code;
            if (c == CHAR_SPACE) bad = 1'b1;
            unique case (phase)
                PH_FIRST: begin
                    if (!alpha(c)) bad = 1'b1;
                    lead  = upcase(c);
                    phase = (lead == CHAR_P) ? PH_AFTER_P : PH_BODY;
                end
                PH_AFTER_P: begin
                    phase = PH_BODY;
                    if (upcase(c) == CHAR_H) begin
                        lead = CHAR_F;
                    end else begin
                        add_body(c);
                    end
                end
                default: begin
                    add_body(c);
                end
            endcase
            if (!last) return;
            code = '0;
            if (bad) begin
                code.bad_word = 1'b1;
            end else begin
                code.lead_letter = lead;
                code.digit_one   = kept[0];
                code.digit_two   = kept[1];
                code.digit_three = kept[2];
            end
            pending_codes.push_back(code);
            clear_word();
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_code(t_result got);
            t_result want;
            if (pending_codes.size() == 0) begin
                report("unexpected result, lead_letter", got.lead_letter, 0);
                return;
            end
            want = pending_codes.pop_front();
            if (got.lead_letter !== want.lead_letter)
                report("lead_letter", got.lead_letter, want.lead_letter);
            if (got.digit_one !== want.digit_one)
                report("digit_one", got.digit_one, want.digit_one);
            if (got.digit_two !== want.digit_two)
                report("digit_two", got.digit_two, want.digit_two);
            if (got.digit_three !== want.digit_three)
                report("digit_three", got.digit_three, want.digit_three);
            if (got.bad_word !== want.bad_word)
                report("bad_word", got.bad_word, want.bad_word);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_in
    logic        s_axis_tlast;   // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] lead_letter, [10:8] digit_one,
                                 // [13:11] digit_two, [16:14] digit_three
    logic        m_axis_tuser;   // [0] bad_word
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    soundex_scoreboard sb = new();
    bit                gaps_on;
    int                cycles = 0;
    int                sent;

    soundex_word_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.lead_letter = m_axis_tdata[7:0];
                got.digit_one   = m_axis_tdata[10:8];
                got.digit_two   = m_axis_tdata[13:11];
                got.digit_three = m_axis_tdata[16:14];
                got.bad_word    = m_axis_tuser;
                sb.check_code(got);
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready = !(gaps_on && $urandom_range(99) < 9);
    end

    task automatic send_byte(input logic [7:0] c, input bit last);
        if (gaps_on && $urandom_range(99) < 9) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = c;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic send_word(input logic [7:0] w [$]);
        foreach (w[k]) send_byte(w[k], k == w.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] w [$];
        for (int k = 0; k < s.len(); k++) w.push_back(s[k]);
        send_word(w);
    endtask

    // Hold the sender until every expected code has come out.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending_codes.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_codes(input logic idx, input logic [CODE_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = {25'($urandom), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_codes(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] random_codes();
        logic [CODE_W-1:0] v;
        for (int k = 0; k < 13; k++) v[3*k +: 3] = 3'($urandom_range(0, 7));
        return v;
    endfunction

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + 8'($urandom_range(0, 25));
    endfunction

    task automatic random_word();
        logic [7:0] w [$];
        int         len;
        int         pick;
        len  = $urandom_range(1, 9);
        pick = $urandom_range(99);
        if (pick < 80) begin
            if ($urandom_range(99) < 25) begin
                w.push_back($urandom_range(0, 1) ? CHAR_P : CHAR_P + CASE_GAP);
                if ($urandom_range(0, 1)) w.push_back($urandom_range(0, 1) ? CHAR_H : CHAR_H + CASE_GAP);
            end
            while (w.size() < len) begin
                w.push_back(($urandom_range(99) < 5) ? 8'($urandom_range(0, 255)) : any_letter());
            end
        end else if (pick < 90) begin
            repeat (len) w.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (len) w.push_back(any_letter());
            if ($urandom_range(0, 1)) begin
                w[$urandom_range(0, len - 1)] = CHAR_SPACE;
            end else begin
                w[0] = 8'($urandom_range(0, 64));
            end
        end
        send_word(w);
    endtask

    initial begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        gaps_on       = 1'b1;
        sent          = 0;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_text("Phone");
        send_text("pH");
        send_text("A");
        send_text("1");
        send_text("a b");
        send_word('{8'h7a, 8'h00, 8'hff, 8'h79});
        send_text("Pbb");
        send_text("Bcdlmr");
        drain();

        for (int p = 0; p < 5; p++) begin
            repeat (4) @(negedge i_clk);
            unique case (p)
                1: begin
                    write_codes(REG_CODES_A_M, CODES_ALL_ZERO);
                    write_codes(REG_CODES_N_Z, CODES_ALL_ONES);
                end
                2: begin
                    write_codes(REG_CODES_A_M, CODES_ALL_ONES);
                    write_codes(REG_CODES_N_Z, CODES_ALL_ZERO);
                end
                default: begin
                    write_codes(REG_CODES_A_M, random_codes());
                    write_codes(REG_CODES_N_Z, random_codes());
                end
            endcase
            gaps_on = (p != 3);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                random_word();
                if (p == 0 && sent >= PHASE_BYTES / 2 && sent < PHASE_BYTES / 2 + 10) drain();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sdx_pkg.sv
rtl/sdx_cfg.sv
rtl/sdx_word.sv
rtl/soundex_word_encoder.sv
rtl/sdx_checker.sv
bench/tb.sv
